// ----- hw/rtl/psp_pkg.sv -----
package psp_pkg;

  localparam int SIZE_BITS_DEF = 24;

  localparam int DATA_W       = 8;
  localparam int FRAME_SIZE_W = 24;
  localparam int PTS_W        = 33;
  localparam int MUX_RATE_W   = 22;
  localparam int MAX_PKT_W    = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_MUX_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PKT  = 2'd1;

  localparam logic [MUX_RATE_W-1:0] MUX_RATE_RST = 22'd5000;
  localparam logic [MAX_PKT_W-1:0]  MAX_PKT_RST  = 24'd65536;

  // The second of a PTS is (pts >> 4) / 5625, since 90000 = 16 * 5625. The
  // division is a multiply by ceil(2^42 / 5625); for a 29-bit operand the
  // product shifted right by 42 is exact.
  localparam int SEC_W           = 17;
  localparam int SEC_PRESHIFT    = 4;
  localparam int SEC_RECIP_W     = 30;
  localparam int SEC_RECIP_SHIFT = 42;
  localparam logic [SEC_RECIP_W-1:0] SEC_RECIP = 30'd781874936;

  localparam int HDR_BYTES   = 14;
  localparam int MAP_BYTES   = 20;
  localparam int CNT_W       = $clog2(MAP_BYTES);
  localparam int HIDX_W      = $clog2(HDR_BYTES);
  localparam int TOT_W       = FRAME_SIZE_W + 1;
  localparam int PES_LEN_ADD = 8;
  localparam int PES_LEN_MAX = 65535;

  localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [31:0] PACK_START = 32'h000001BA;
  localparam logic [7:0]  PES_STREAM_ID = 8'hE0;

  localparam logic [7:0] PSM_BODY [16] = '{
    8'h00, 8'h00, 8'h01, 8'hBC, 8'h00, 8'h0E, 8'hE1, 8'hFF,
    8'h00, 8'h00, 8'h00, 8'h04, 8'h1B, 8'hE0, 8'h00, 8'h00
  };

  function automatic logic [31:0] psm_crc_calc();
    logic [31:0] crc;
    crc = CRC_INIT;
    for (int i = 0; i < 16; i++) begin
      crc = crc ^ {PSM_BODY[i], 24'h0};
      for (int j = 0; j < 8; j++) begin
        crc = crc[31] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
      end
    end
    return crc;
  endfunction

  localparam logic [31:0] PSM_CRC = psm_crc_calc();

  function automatic logic [7:0] psm_byte(input logic [CNT_W-1:0] idx);
    logic [7:0] b;
    if (idx < CNT_W'(16)) begin
      b = PSM_BODY[idx[3:0]];
    end else begin
      case (idx[1:0])
        2'd0:    b = PSM_CRC[31:24];
        2'd1:    b = PSM_CRC[23:16];
        2'd2:    b = PSM_CRC[15:8];
        default: b = PSM_CRC[7:0];
      endcase
    end
    return b;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_PACK,
    ST_MAP,
    ST_PES,
    ST_DATA,
    ST_ERR
  } state_t;

  typedef enum logic [2:0] {
    SEG_PACK,
    SEG_MAP,
    SEG_PES,
    SEG_DATA,
    SEG_ERR
  } seg_t;

  typedef struct packed {
    logic frame_load;
    logic pay_accept;
    logic div_step;
    logic decide;
    logic emit;
    seg_t seg;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic overflow;
    logic map_sel;
    logic seg_end;
    logic size_zero;
  } ctrl_stat_t;

endpackage

// ----- hw/rtl/psp_in_if.sv -----
interface psp_in_if;
  logic                                valid;
  logic                                ready;
  logic [psp_pkg::DATA_W-1:0]          data_byte;
  logic                                first_of_frame;
  logic [psp_pkg::FRAME_SIZE_W-1:0]    frame_size;
  logic [psp_pkg::PTS_W-1:0]           pts;
  logic                                key_frame;

  modport source (output valid, data_byte, first_of_frame, frame_size, pts, key_frame,
                  input ready);
  modport sink (input valid, data_byte, first_of_frame, frame_size, pts, key_frame,
                output ready);
endinterface

// ----- hw/rtl/psp_out_if.sv -----
interface psp_out_if;
  logic                       valid;
  logic                       ready;
  logic [psp_pkg::DATA_W-1:0] out_byte;
  logic                       last_of_packet;
  logic                       overflow_error;

  modport source (output valid, out_byte, last_of_packet, overflow_error, input ready);
  modport sink (input valid, out_byte, last_of_packet, overflow_error, output ready);
endinterface

// ----- hw/rtl/psp_cfg_if.sv -----
interface psp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [psp_pkg::CFG_IDX_W-1:0]    index;
  logic [psp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/psp_ctrl.sv -----
module psp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_first,
  output logic                 in_ready,
  input  psp_pkg::ctrl_stat_t  stat,
  output psp_pkg::ctrl_cmd_t   cmd
);

  psp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.seg        = psp_pkg::SEG_PACK;
    case (state_r)
      psp_pkg::ST_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          if (in_first) begin
            cmd.frame_load = 1'b1;
            state_nxt      = psp_pkg::ST_DIV;
          end else begin
            cmd.pay_accept = 1'b1;
          end
        end
      end
      psp_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = psp_pkg::ST_CHECK;
      end
      psp_pkg::ST_CHECK: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.overflow ? psp_pkg::ST_ERR : psp_pkg::ST_PACK;
      end
      psp_pkg::ST_PACK: begin
        cmd.seg  = psp_pkg::SEG_PACK;
        cmd.emit = stat.out_free;
        if (stat.out_free && stat.seg_end) begin
          state_nxt = stat.map_sel ? psp_pkg::ST_MAP : psp_pkg::ST_PES;
        end
      end
      psp_pkg::ST_MAP: begin
        cmd.seg  = psp_pkg::SEG_MAP;
        cmd.emit = stat.out_free;
        if (stat.out_free && stat.seg_end) begin
          state_nxt = psp_pkg::ST_PES;
        end
      end
      psp_pkg::ST_PES: begin
        cmd.seg  = psp_pkg::SEG_PES;
        cmd.emit = stat.out_free;
        if (stat.out_free && stat.seg_end) begin
          state_nxt = stat.size_zero ? psp_pkg::ST_IDLE : psp_pkg::ST_DATA;
        end
      end
      psp_pkg::ST_DATA: begin
        cmd.seg  = psp_pkg::SEG_DATA;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_nxt = psp_pkg::ST_IDLE;
        end
      end
      psp_pkg::ST_ERR: begin
        cmd.seg  = psp_pkg::SEG_ERR;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_nxt = psp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = psp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/psp_datapath.sv -----
module psp_datapath #(
  parameter int SIZE_BITS = psp_pkg::SIZE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [psp_pkg::DATA_W-1:0]          in_data_byte,
  input  logic [psp_pkg::FRAME_SIZE_W-1:0]    in_frame_size,
  input  logic [psp_pkg::PTS_W-1:0]           in_pts,
  input  logic                                in_key_frame,
  input  logic                                cfg_valid,
  input  logic [psp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  psp_pkg::ctrl_cmd_t                  cmd,
  output psp_pkg::ctrl_stat_t                 stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [psp_pkg::DATA_W-1:0]          out_byte,
  output logic                                out_last,
  output logic                                out_err
);

  localparam int SZ_W = (SIZE_BITS < psp_pkg::FRAME_SIZE_W) ? SIZE_BITS
                                                            : psp_pkg::FRAME_SIZE_W;
  localparam int PROD_W = psp_pkg::PTS_W - psp_pkg::SEC_PRESHIFT + psp_pkg::SEC_RECIP_W;

  // Configuration registers.
  logic [psp_pkg::MUX_RATE_W-1:0] mux_rate_r;
  logic [psp_pkg::MAX_PKT_W-1:0]  max_pkt_r;

  // Frame metadata captured on the first item.
  logic [psp_pkg::PTS_W-1:0]  pts_r;
  logic [SZ_W-1:0]            size_r;
  logic [psp_pkg::DATA_W-1:0] data_r;
  logic                       key_r;

  // Second of the PTS.
  logic [PROD_W-1:0]          sec_prod;
  logic [psp_pkg::SEC_W-1:0]  q_r;

  // Stream state.
  logic [psp_pkg::SEC_W-1:0]  last_sec_r;
  logic [SZ_W-1:0]            bytes_left_r;
  logic                       dropping_r;
  logic                       map_r;
  logic [psp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                       out_valid_r;
  logic [psp_pkg::DATA_W-1:0] out_byte_r;
  logic                       out_last_r;
  logic                       out_err_r;

  logic                       map_c;
  logic [psp_pkg::TOT_W-1:0]  total_c;
  logic                       ovf_c;
  logic [psp_pkg::MUX_RATE_W-1:0] rate_eff;
  logic [SZ_W:0]              pes_sum;
  logic [15:0]                pes_len;
  logic [111:0]               pack_vec;
  logic [111:0]               pes_vec;
  logic [7:0]                 pack_b [psp_pkg::HDR_BYTES];
  logic [7:0]                 pes_b  [psp_pkg::HDR_BYTES];
  logic                       seg_end;
  logic                       size_zero;
  logic                       out_free;
  logic [psp_pkg::DATA_W-1:0] sel_byte;
  logic                       sel_last;
  logic                       sel_err;
  logic                       pay_live;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mux_rate_r <= psp_pkg::MUX_RATE_RST;
      max_pkt_r  <= psp_pkg::MAX_PKT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        psp_pkg::CFG_MUX_RATE: mux_rate_r <= cfg_data[psp_pkg::MUX_RATE_W-1:0];
        psp_pkg::CFG_MAX_PKT:  max_pkt_r  <= cfg_data[psp_pkg::MAX_PKT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_load) begin
      pts_r  <= in_pts;
      size_r <= in_frame_size[SZ_W-1:0];
      data_r <= in_data_byte;
      key_r  <= in_key_frame;
    end
  end

  // The low four PTS bits never change the quotient, so the multiply is 29 by 30 bits.
  assign sec_prod = PROD_W'(pts_r[psp_pkg::PTS_W-1:psp_pkg::SEC_PRESHIFT]) *
                    PROD_W'(psp_pkg::SEC_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      q_r <= sec_prod[psp_pkg::SEC_RECIP_SHIFT +: psp_pkg::SEC_W];
    end
  end

  assign map_c   = key_r || (q_r > last_sec_r);
  assign total_c = psp_pkg::TOT_W'(size_r) +
                   (map_c ? psp_pkg::TOT_W'(2 * psp_pkg::HDR_BYTES + psp_pkg::MAP_BYTES)
                          : psp_pkg::TOT_W'(2 * psp_pkg::HDR_BYTES));
  assign ovf_c   = total_c > psp_pkg::TOT_W'(max_pkt_r);

  assign size_zero = (size_r == '0);
  assign pay_live  = cmd.pay_accept && (bytes_left_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sec_r   <= '0;
      bytes_left_r <= '0;
      dropping_r   <= 1'b0;
      map_r        <= 1'b0;
    end else if (cmd.decide) begin
      map_r        <= map_c;
      if (map_c) begin
        last_sec_r <= q_r;
      end
      bytes_left_r <= size_zero ? '0 : size_r - SZ_W'(1);
      dropping_r   <= ovf_c;
    end else if (pay_live) begin
      bytes_left_r <= bytes_left_r - SZ_W'(1);
    end
  end

  // Header byte images.
  assign rate_eff = (mux_rate_r == '0) ? psp_pkg::MUX_RATE_W'(1) : mux_rate_r;
  assign pack_vec = {psp_pkg::PACK_START, 2'b01, pts_r[32:30], 1'b1, pts_r[29:15], 1'b1,
                     pts_r[14:0], 1'b1, 9'd0, 1'b1, rate_eff, 2'b11, 5'h1F, 3'd0};

  assign pes_sum = {1'b0, size_r} + (SZ_W+1)'(psp_pkg::PES_LEN_ADD);
  assign pes_len = (pes_sum > (SZ_W+1)'(psp_pkg::PES_LEN_MAX)) ? 16'd0 : pes_sum[15:0];
  assign pes_vec = {24'h000001, psp_pkg::PES_STREAM_ID, pes_len, 8'h84, 8'h80, 8'h05,
                    4'h2, pts_r[32:30], 1'b1, pts_r[29:22], pts_r[21:15], 1'b1,
                    pts_r[14:7], pts_r[6:0], 1'b1};

  for (genvar g = 0; g < psp_pkg::HDR_BYTES; g++) begin : g_hdr
    assign pack_b[g] = pack_vec[111 - 8*g -: 8];
    assign pes_b[g]  = pes_vec[111 - 8*g -: 8];
  end

  assign seg_end = (cmd.seg == psp_pkg::SEG_MAP)
                 ? (cnt_r == psp_pkg::CNT_W'(psp_pkg::MAP_BYTES - 1))
                 : (cnt_r == psp_pkg::CNT_W'(psp_pkg::HDR_BYTES - 1));

  always_comb begin
    sel_byte = '0;
    sel_last = 1'b0;
    sel_err  = 1'b0;
    case (cmd.seg)
      psp_pkg::SEG_PACK: sel_byte = pack_b[cnt_r[psp_pkg::HIDX_W-1:0]];
      psp_pkg::SEG_MAP:  sel_byte = psp_pkg::psm_byte(cnt_r);
      psp_pkg::SEG_PES: begin
        sel_byte = pes_b[cnt_r[psp_pkg::HIDX_W-1:0]];
        sel_last = size_zero && seg_end;
      end
      psp_pkg::SEG_DATA: begin
        sel_byte = data_r;
        sel_last = (size_r == SZ_W'(1));
      end
      psp_pkg::SEG_ERR: begin
        sel_last = 1'b1;
        sel_err  = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.emit) begin
      if ((cmd.seg == psp_pkg::SEG_PACK || cmd.seg == psp_pkg::SEG_MAP ||
           cmd.seg == psp_pkg::SEG_PES) && !seg_end) begin
        cnt_nxt = cnt_r + psp_pkg::CNT_W'(1);
      end else begin
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Output register; a new result loads in the cycle the old one transfers.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || (pay_live && !dropping_r)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= sel_byte;
      out_last_r <= sel_last;
      out_err_r  <= sel_err;
    end else if (pay_live && !dropping_r) begin
      out_byte_r <= in_data_byte;
      out_last_r <= (bytes_left_r == SZ_W'(1));
      out_err_r  <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_err   = out_err_r;

  assign stat.out_free  = out_free;
  assign stat.overflow  = ovf_c;
  assign stat.map_sel   = map_r;
  assign stat.seg_end   = seg_end;
  assign stat.size_zero = size_zero;

endmodule

// ----- hw/rtl/program_stream_packetizer_unit.sv -----
// MPEG-2 program stream packetizer. Each frame opens with an item that carries
// its PTS, key flag and size together with the first payload byte; the block
// answers it with a pack header, an optional program stream map, a PES header
// and, unless the frame is empty, that first byte, or with a single overflow
// result when the packet would not fit in max_packet_bytes. After the transfer
// of the first item of a frame the block finds the PTS second by a reciprocal
// multiply, makes the map decision and size check, and then loads the first
// header byte into the output register. Then follow 29 or 49 output bytes
// (28 or 48 for an empty frame) or a single overflow result, one byte per
// cycle while the output side keeps up; no new item is taken until the
// frame's last result is in the output register. Every later payload item is
// accepted whenever the output register is free, so payload streams at one
// byte per clock. Configuration writes are always accepted and should only be
// made while the block is idle.
module program_stream_packetizer_unit #(
  parameter int SIZE_BITS = psp_pkg::SIZE_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  psp_in_if.sink     in_chan,
  psp_out_if.source  out_chan,
  psp_cfg_if.sink    cfg_chan
);

  psp_pkg::ctrl_cmd_t  cmd;
  psp_pkg::ctrl_stat_t stat;

  assign cfg_chan.ready = 1'b1;

  psp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_first (in_chan.first_of_frame),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psp_datapath #(
    .SIZE_BITS (SIZE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_data_byte  (in_chan.data_byte),
    .in_frame_size (in_chan.frame_size),
    .in_pts        (in_chan.pts),
    .in_key_frame  (in_chan.key_frame),
    .cfg_valid     (cfg_chan.valid),
    .cfg_index     (cfg_chan.index),
    .cfg_data      (cfg_chan.data),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_chan.ready),
    .out_valid     (out_chan.valid),
    .out_byte      (out_chan.out_byte),
    .out_last      (out_chan.last_of_packet),
    .out_err       (out_chan.overflow_error)
  );

  // A frame start keeps the input closed while its second is computed.
  a_busy_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.first_of_frame) |=> !in_chan.ready)
    else $error("input accepted during frame header setup");

  // The overflow result is a zero byte that closes the packet.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.overflow_error) |->
      (out_chan.last_of_packet && out_chan.out_byte == '0))
    else $error("malformed overflow result");

  // Header bytes are never produced in the cycle after a frame start transfer.
  a_no_early_output: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.first_of_frame) |=>
      (!out_chan.valid || $past(out_chan.valid)))
    else $error("output started before frame decode");

endmodule

// ----- sim/psp_stream_check.sv -----
`timescale 1ns / 100ps

module psp_stream_check (
  input  logic clk,
  input  logic rst_n,
  psp_in_if    in_mon,
  psp_out_if   out_mon,
  psp_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);

  localparam logic [31:0] PACK_START_CODE = 32'h000001BA;
  localparam logic [31:0] CRC_POLY        = 32'h04C11DB7;
  localparam logic [32:0] TICKS_PER_SEC   = 33'd90000;
  localparam logic [24:0] HDR_LEN         = 25'd14;
  localparam logic [24:0] MAP_LEN         = 25'd20;
  localparam logic [24:0] PES_LEN_LIMIT   = 25'd65535;
  localparam logic [24:0] PES_LEN_EXTRA   = 25'd8;
  localparam logic [7:0]  STREAM_ID_VIDEO = 8'hE0;
  localparam logic [7:0]  PES_FLAGS_HI    = 8'h84;
  localparam logic [7:0]  PES_FLAGS_LO    = 8'h80;
  localparam logic [7:0]  PES_HDR_DATA    = 8'h05;

  localparam logic [7:0] MAP_BODY [16] = '{
    8'h00, 8'h00, 8'h01, 8'hBC, 8'h00, 8'h0E, 8'hE1, 8'hFF,
    8'h00, 8'h00, 8'h00, 8'h04, 8'h1B, 8'hE0, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       err;
  } stream_byte_t;

  stream_byte_t expected_bytes[$];

  logic [21:0] mux_rate_q;
  logic [23:0] max_pkt_q;
  logic [16:0] map_second;
  logic [23:0] payload_left;
  logic        swallowing;

  function automatic logic [31:0] map_body_crc();
    logic [31:0] crc;
    crc = 32'hFFFFFFFF;
    foreach (MAP_BODY[i]) begin
      crc ^= {MAP_BODY[i], 24'h0};
      repeat (8) crc = crc[31] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
    end
    return crc;
  endfunction

  function automatic void queue_byte(input logic [7:0] value, input logic last,
                                     input logic err);
    stream_byte_t b;
    b.value = value;
    b.last  = last;
    b.err   = err;
    expected_bytes.push_back(b);
  endfunction

  task automatic predict_packet(input logic [7:0] data, input logic first,
                                input logic [23:0] size, input logic [32:0] pts,
                                input logic key);
    logic [16:0]  sec;
    logic         send_map;
    logic [24:0]  total;
    logic [24:0]  pes_len;
    logic [21:0]  rate;
    logic [111:0] pack_hdr;
    logic [31:0]  crc;
    if (first) begin
      sec = 17'(pts / TICKS_PER_SEC);
      send_map = key || (sec > map_second);
      // The second is remembered even when the frame is dropped below.
      if (send_map) map_second = sec;
      total = HDR_LEN + HDR_LEN + (send_map ? MAP_LEN : 25'd0) + 25'(size);
      payload_left = (size != 0) ? size - 24'd1 : 24'd0;
      if (total > 25'(max_pkt_q)) begin
        swallowing = 1'b1;
        queue_byte(8'h00, 1'b1, 1'b1);
        return;
      end
      swallowing = 1'b0;
      rate = (mux_rate_q == 0) ? 22'd1 : mux_rate_q;
      pack_hdr = {PACK_START_CODE, 2'b01, pts[32:30], 1'b1, pts[29:15], 1'b1,
                  pts[14:0], 1'b1, 9'd0, 1'b1, rate, 2'b11, 5'h1F, 3'b000};
      for (int i = 0; i < 14; i++) queue_byte(pack_hdr[111-8*i -: 8], 1'b0, 1'b0);
      if (send_map) begin
        crc = map_body_crc();
        foreach (MAP_BODY[i]) queue_byte(MAP_BODY[i], 1'b0, 1'b0);
        for (int i = 0; i < 4; i++) queue_byte(crc[31-8*i -: 8], 1'b0, 1'b0);
      end
      pes_len = 25'(size) + PES_LEN_EXTRA;
      if (pes_len > PES_LEN_LIMIT) pes_len = 25'd0;
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'h01, 1'b0, 1'b0);
      queue_byte(STREAM_ID_VIDEO, 1'b0, 1'b0);
      queue_byte(pes_len[15:8], 1'b0, 1'b0);
      queue_byte(pes_len[7:0], 1'b0, 1'b0);
      queue_byte(PES_FLAGS_HI, 1'b0, 1'b0);
      queue_byte(PES_FLAGS_LO, 1'b0, 1'b0);
      queue_byte(PES_HDR_DATA, 1'b0, 1'b0);
      queue_byte({4'b0010, pts[32:30], 1'b1}, 1'b0, 1'b0);
      queue_byte(pts[29:22], 1'b0, 1'b0);
      queue_byte({pts[21:15], 1'b1}, 1'b0, 1'b0);
      queue_byte(pts[14:7], 1'b0, 1'b0);
      queue_byte({pts[6:0], 1'b1}, size == 0, 1'b0);
      if (size != 0) queue_byte(data, size == 1, 1'b0);
    end else if (payload_left != 0) begin
      payload_left = payload_left - 24'd1;
      if (!swallowing) queue_byte(data, payload_left == 0, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    stream_byte_t want;
    if (!rst_n) begin
      fail_count   = 0;
      mux_rate_q   = psp_pkg::MUX_RATE_RST;
      max_pkt_q    = psp_pkg::MAX_PKT_RST;
      map_second   = '0;
      payload_left = '0;
      swallowing   = 1'b0;
      expected_bytes.delete();
    end else begin
      // Results at this edge can only stem from items accepted earlier.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("output transfer with nothing expected: out_byte %0h", out_mon.out_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_mon.out_byte !== want.value) begin
            $error("out_byte: expected %0h, actual %0h", want.value, out_mon.out_byte);
            fail_count++;
          end
          if (out_mon.last_of_packet !== want.last) begin
            $error("last_of_packet: expected %0b, actual %0b", want.last,
                   out_mon.last_of_packet);
            fail_count++;
          end
          if (out_mon.overflow_error !== want.err) begin
            $error("overflow_error: expected %0b, actual %0b", want.err,
                   out_mon.overflow_error);
            fail_count++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == psp_pkg::CFG_MUX_RATE) mux_rate_q = cfg_mon.data[21:0];
        else if (cfg_mon.index == psp_pkg::CFG_MAX_PKT) max_pkt_q = cfg_mon.data[23:0];
      end
      if (in_mon.valid && in_mon.ready)
        predict_packet(in_mon.data_byte, in_mon.first_of_frame, in_mon.frame_size,
                       in_mon.pts, in_mon.key_frame);
    end
    pending = expected_bytes.size();
  end

endmodule

// ----- sim/program_stream_packetizer_unit_tb.sv -----
`timescale 1ns / 100ps

module program_stream_packetizer_unit_tb;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 64;
  localparam int PAYLOAD_CAP      = 60;
  localparam int PHASE_ITEMS      = 20;
  localparam logic [32:0] TICKS   = 33'd90000;
  localparam logic [32:0] PTS_MAX = {33{1'b1}};
  localparam logic [psp_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   frame_items;
  bit   tx_idle;
  bit   rx_idle;
  bit   long_hold;
  bit   hold_done;

  psp_in_if  in_chan ();
  psp_out_if out_chan ();
  psp_cfg_if cfg_chan ();

  program_stream_packetizer_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  psp_stream_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_mon    (cfg_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [32:0] rand_pts();
    return {1'($urandom_range(0, 1)), 32'($urandom)};
  endfunction

  // Called right after a falling edge; returns right after the falling edge that
  // follows the transfer, with valid still high.
  task automatic push_item(input logic [7:0] data, input logic first,
                           input logic [23:0] size, input logic [32:0] pts,
                           input logic key);
    int gap;
    gap = tx_idle ? int'($urandom_range(0, 16)) : 0;
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid          = 1'b1;
    in_chan.data_byte      = data;
    in_chan.first_of_frame = first;
    in_chan.frame_size     = size;
    in_chan.pts            = pts;
    in_chan.key_frame      = key;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [23:0] size, input logic [32:0] pts,
                            input logic key, input int n_pay, input logic [7:0] head_data);
    push_item(head_data, 1'b1, size, pts, key);
    for (int i = 0; i < n_pay; i++)
      push_item(8'($urandom), 1'b0, 24'($urandom), rand_pts(), 1'($urandom));
    frame_items += 1 + n_pay;
  endtask

  task automatic send_stray();
    push_item(8'($urandom), 1'b0, 24'($urandom), rand_pts(), 1'($urandom));
  endtask

  task automatic wait_drained();
    in_chan.valid = 1'b0;
    wait (pending == 0);
    // Swallowed payload and stray bytes leave no trace in the result count.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [psp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psp_pkg::CFG_DATA_W-1:0] data);
    cfg_chan.valid = 1'b1;
    cfg_chan.index = idx;
    cfg_chan.data  = data;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  task automatic random_frame();
    int          kind;
    int          n_pay;
    logic [23:0] size;
    logic [32:0] pts;
    kind = int'($urandom_range(0, 99));
    if (kind < 55) size = 24'($urandom_range(0, 8));
    else if (kind < 80) size = 24'($urandom_range(9, 40));
    else if (kind < 90) size = 24'($urandom);
    else size = 24'($urandom_range(41, 80));
    if ($urandom_range(0, 9) < 7)
      pts = 33'($urandom_range(0, 30)) * TICKS + 33'($urandom_range(0, 89999));
    else
      pts = rand_pts();
    n_pay = (size == 0) ? 0 : int'(size) - 1;
    if (n_pay > PAYLOAD_CAP) n_pay = PAYLOAD_CAP;
    // Now and then the frame is cut short by the next one.
    if ($urandom_range(0, 9) == 0) n_pay = int'($urandom_range(0, n_pay));
    send_frame(size, pts, $urandom_range(0, 3) == 0, n_pay, 8'($urandom));
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) send_stray();
  endtask

  initial begin
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int gap;
      @(negedge clk);
      if (long_hold && !hold_done) begin
        out_chan.ready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      gap = rx_idle ? int'($urandom_range(0, 16)) : 0;
      if (gap > 0) begin
        out_chan.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_chan.ready = 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  initial begin
    rst_n                  = 1'b0;
    frame_items            = 0;
    tx_idle                = 1'b1;
    rx_idle                = 1'b1;
    long_hold              = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.data_byte      = '0;
    in_chan.first_of_frame = 1'b0;
    in_chan.frame_size     = '0;
    in_chan.pts            = '0;
    in_chan.key_frame      = 1'b0;
    cfg_chan.valid         = 1'b0;
    cfg_chan.index         = psp_pkg::CFG_MUX_RATE;
    cfg_chan.data          = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (SETTLE_CYCLES) @(negedge clk);

    // Reset register values: empty frame, key frame, second advance and fall back.
    send_frame(24'd0, 33'd0, 1'b0, 0, 8'hFF);
    send_frame(24'd1, 33'd0, 1'b1, 0, 8'hFF);
    send_frame(24'd3, TICKS * 7 + 33'd5, 1'b0, 2, 8'h00);
    send_frame(24'd2, TICKS * 3, 1'b0, 1, 8'hA5);
    send_stray();
    send_frame(24'd4, TICKS * 9, 1'b0, 1, 8'h5A);
    send_frame(24'd0, TICKS * 9, 1'b1, 0, 8'h00);
    // Overflow still records the second of the map it decided on.
    send_frame(24'hFFFFFF, TICKS * 20, 1'b0, 3, 8'hFF);
    send_frame(24'd1, TICKS * 20 + 33'd1, 1'b0, 0, 8'h11);
    wait_drained();

    write_reg(psp_pkg::CFG_MUX_RATE, 24'd0);
    write_reg(psp_pkg::CFG_MAX_PKT, 24'hFFFFFF);
    send_frame(24'd65527, PTS_MAX, 1'b0, 2, 8'h80);
    send_frame(24'd65528, 33'd0, 1'b1, 1, 8'h7F);
    send_frame(24'hFFFFFF, PTS_MAX, 1'b0, 0, 8'h01);
    wait_drained();

    write_reg(psp_pkg::CFG_MUX_RATE, 24'hFFFFFF);
    write_reg(psp_pkg::CFG_MAX_PKT, 24'd0);
    write_reg(CFG_SPARE_IDX, 24'd77);
    send_frame(24'd0, 33'd0, 1'b0, 0, 8'h00);
    send_frame(24'd5, TICKS, 1'b1, 4, 8'hC3);
    wait_drained();

    write_reg(psp_pkg::CFG_MAX_PKT, 24'd28);
    send_frame(24'd0, 33'd0, 1'b0, 0, 8'h00);
    send_frame(24'd1, 33'd0, 1'b0, 0, 8'hFF);
    wait_drained();
    write_reg(psp_pkg::CFG_MAX_PKT, 24'd48);
    send_frame(24'd0, TICKS * 2, 1'b1, 0, 8'h00);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(psp_pkg::CFG_MUX_RATE, 24'($urandom_range(1, 4194303)));
          write_reg(psp_pkg::CFG_MAX_PKT, 24'hFFFFFF);
        end
        1: begin
          write_reg(psp_pkg::CFG_MUX_RATE, 24'd1);
          write_reg(psp_pkg::CFG_MAX_PKT, 24'd65536);
          long_hold = 1'b1;
        end
        2: begin
          write_reg(psp_pkg::CFG_MUX_RATE, 24'd4194303);
          write_reg(psp_pkg::CFG_MAX_PKT, 24'($urandom_range(28, 120)));
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
        default: begin
          write_reg(psp_pkg::CFG_MUX_RATE, 24'($urandom));
          write_reg(psp_pkg::CFG_MAX_PKT, 24'($urandom_range(40, 400)));
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
      endcase
      frame_items = 0;
      while (frame_items < PHASE_ITEMS) random_frame();
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
